[src/gbcyi_pkg.sv]
// Shared types and constants for the gyro bias calibration and yaw integration block.
`default_nettype none
package gbcyi_pkg;

  localparam int AXES = 3;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W = 6;
  localparam logic signed [22:0] RAD2DEG_Q16 = 23'sd3754936;
  localparam logic [15:0] TARGET_RESET = 16'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_DLOAD,
    ST_DIV,
    ST_BIAS,
    ST_CORR,
    ST_YMUL,
    ST_YACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       conv;
    logic [1:0] axis;
    logic       div_load;
    logic       div_step;
    logic       bias_upd;
    logic       corr;
    logic       ymul;
    logic       yacc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic calib_needed;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[src/gbcyi_div.sv]
// Bit-serial signed-by-unsigned divider lane, quotient truncated toward zero.
`default_nettype none
module gbcyi_div (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic               step,
  input  wire logic signed [32:0] dividend,
  input  wire logic        [15:0] divisor,
  output logic             [31:0] quotient
);

  logic        neg;
  logic [32:0] work;
  logic [15:0] rem;
  logic [15:0] dvsr;
  logic [16:0] trial;
  logic [16:0] trial_sub;
  logic        ge;
  logic [32:0] mag;

  assign mag       = dividend[32] ? 33'(-dividend) : 33'(dividend);
  assign trial     = {rem, work[32]};
  assign ge        = trial >= {1'b0, dvsr};
  assign trial_sub = trial - {1'b0, dvsr};
  assign quotient  = neg ? (32'd0 - work[31:0]) : work[31:0];

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= dividend[32];
      work <= mag;
      rem  <= '0;
      dvsr <= divisor;
    end else if (step) begin
      rem  <= ge ? trial_sub[15:0] : trial[15:0];
      work <= {work[31:0], ge};
    end
  end

endmodule
`default_nettype wire

[src/gbcyi_ctrl.sv]
// Sequencing state machine for one item: convert, average, correct, integrate, emit.
`default_nettype none
module gbcyi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire gbcyi_pkg::status_t sts,
  output gbcyi_pkg::cmd_t         cmd
);

  gbcyi_pkg::state_t                  state;
  gbcyi_pkg::state_t                  state_next;
  logic [gbcyi_pkg::CNT_W-1:0]        cnt;
  logic [gbcyi_pkg::CNT_W-1:0]        cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbcyi_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      gbcyi_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) state_next = gbcyi_pkg::ST_CONV;
      end
      gbcyi_pkg::ST_CONV: begin
        if (sts.err) begin
          state_next = gbcyi_pkg::ST_OUT;
        end else if (cnt == gbcyi_pkg::CNT_W'(gbcyi_pkg::AXES - 1)) begin
          cnt_next   = '0;
          state_next = sts.calib_needed ? gbcyi_pkg::ST_DLOAD : gbcyi_pkg::ST_CORR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      gbcyi_pkg::ST_DLOAD: begin
        cnt_next   = '0;
        state_next = gbcyi_pkg::ST_DIV;
      end
      gbcyi_pkg::ST_DIV: begin
        if (cnt == gbcyi_pkg::CNT_W'(gbcyi_pkg::DIV_STEPS - 1)) begin
          state_next = gbcyi_pkg::ST_BIAS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      gbcyi_pkg::ST_BIAS: state_next = gbcyi_pkg::ST_CORR;
      gbcyi_pkg::ST_CORR: state_next = gbcyi_pkg::ST_YMUL;
      gbcyi_pkg::ST_YMUL: state_next = gbcyi_pkg::ST_YACC;
      gbcyi_pkg::ST_YACC: state_next = gbcyi_pkg::ST_OUT;
      gbcyi_pkg::ST_OUT: begin
        if (sts.out_free) state_next = gbcyi_pkg::ST_IDLE;
      end
      default: state_next = gbcyi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = cnt[1:0];
    s_tready = 1'b0;
    case (state)
      gbcyi_pkg::ST_IDLE: begin
        s_tready = ~rst;
        cmd.take = s_tvalid & ~rst;
      end
      gbcyi_pkg::ST_CONV:  cmd.conv     = ~sts.err;
      gbcyi_pkg::ST_DLOAD: cmd.div_load = 1'b1;
      gbcyi_pkg::ST_DIV:   cmd.div_step = 1'b1;
      gbcyi_pkg::ST_BIAS:  cmd.bias_upd = 1'b1;
      gbcyi_pkg::ST_CORR:  cmd.corr     = 1'b1;
      gbcyi_pkg::ST_YMUL:  cmd.ymul     = 1'b1;
      gbcyi_pkg::ST_YACC:  cmd.yacc     = 1'b1;
      gbcyi_pkg::ST_OUT:   cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/gbcyi_dp.sv]
// Datapath: rate conversion, bias averaging, correction, yaw integration, output register.
`default_nettype none
module gbcyi_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gbcyi_pkg::cmd_t    cmd,
  output gbcyi_pkg::status_t      sts,
  input  wire logic               cfg_we,
  input  wire logic        [15:0] cfg_wdata,
  input  wire logic        [87:0] s_tdata,
  input  wire logic         [0:0] s_tuser,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic            [175:0] m_tdata,
  output logic              [1:0] m_tuser
);

  logic signed [23:0] rate_in [gbcyi_pkg::AXES];
  logic        [15:0] dt;
  logic               rf;
  logic signed [29:0] dps [gbcyi_pkg::AXES];
  logic signed [31:0] bias [gbcyi_pkg::AXES];
  logic signed [31:0] last [gbcyi_pkg::AXES];
  logic        [31:0] quo [gbcyi_pkg::AXES];
  logic signed [32:0] diff [gbcyi_pkg::AXES];
  logic        [15:0] target;
  logic        [15:0] bias_count;
  logic        [15:0] divisor;
  logic               bias_done;
  logic        [47:0] yaw;
  logic        [31:0] good_count;
  logic               error_latched;
  logic signed [47:0] yprod;
  logic signed [46:0] prod;
  logic signed [23:0] rate_sel;

  assign rate_sel = rate_in[cmd.axis];
  assign prod     = rate_sel * gbcyi_pkg::RAD2DEG_Q16;
  assign divisor  = bias_count + 16'd1;

  assign sts.err          = error_latched | rf;
  assign sts.calib_needed = bias_count < target;
  assign sts.out_free     = ~m_tvalid | m_tready;

  for (genvar i = 0; i < gbcyi_pkg::AXES; i++) begin : g_axis
    assign diff[i] = 33'(dps[i]) - 33'(bias[i]);

    gbcyi_div u_div (
      .clk      (clk),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (diff[i]),
      .divisor  (divisor),
      .quotient (quo[i])
    );

    always_ff @(posedge clk) begin
      if (cmd.take) rate_in[i] <= s_tdata[24*i +: 24];
      if (cmd.conv && cmd.axis == 2'(i)) dps[i] <= prod[45:16];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        bias[i] <= '0;
        last[i] <= '0;
      end else begin
        if (cmd.bias_upd) bias[i] <= bias[i] + $signed(quo[i]);
        if (cmd.corr) last[i] <= 32'(dps[i]) - bias[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dt <= s_tdata[87:72];
      rf <= s_tuser[0];
    end
    if (cmd.ymul) yprod <= last[2] * $signed({1'b0, dt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target        <= gbcyi_pkg::TARGET_RESET;
      bias_count    <= '0;
      bias_done     <= 1'b0;
      yaw           <= '0;
      good_count    <= '0;
      error_latched <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) target <= cfg_wdata;
      if (cmd.bias_upd) begin
        bias_count <= divisor;
        if (divisor == target) bias_done <= 1'b1;
      end
      if (cmd.yacc) begin
        good_count <= good_count + 32'd1;
        if (bias_done) yaw <= yaw + 48'($signed(yprod[47:20]));
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
        if (sts.err) error_latched <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {good_count, yaw, last[2], last[1], last[0]};
      m_tuser <= {bias_done, sts.err};
    end
  end

endmodule
`default_nettype wire

[src/gyro_bias_calibrate_yaw_integrate_core.sv]
// Top level of the gyro bias calibration and yaw integration block.
// While averaging the bias, each item passes through the 33-step bit-serial divider
// (one per axis, three lanes in parallel); once done it skips the divider, and an item
// taken with a read failure or a latched error goes straight to the output register.
// The output register lets the next item enter while a result waits. Synchronous
// active-high reset clears control state, bias, yaw, counts, flags, target and m_tvalid.
`default_nettype none
module gyro_bias_calibrate_yaw_integrate_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic  [15:0] cfg_wdata,  // bias_sample_target
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic  [87:0] s_tdata,    // rate_x_rad, rate_y_rad, rate_z_rad, step_time
  input  wire logic   [0:0] s_tuser,    // read_failed
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [175:0] m_tdata,    // corrected_x/y/z_dps, heading_deg, samples_seen
  output logic        [1:0] m_tuser     // result_status, calibrated
);

  gbcyi_pkg::cmd_t    cmd;
  gbcyi_pkg::status_t sts;

  gbcyi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbcyi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking stream testbench for gyro_bias_calibrate_yaw_integrate_core.
`default_nettype none
module testbench;

  localparam longint RAD_TO_DEG_Q16 = 64'sd3754936;
  localparam logic [15:0] TARGET_AT_RESET = 16'd1000;

  typedef struct packed {
    logic        status;
    logic [31:0] x_dps;
    logic [31:0] y_dps;
    logic [31:0] z_dps;
    logic [47:0] heading;
    logic        calibrated;
    logic [31:0] seen;
  } gyro_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [87:0] s_tdata;
  logic [0:0] s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic [1:0] m_tuser;

  gyro_result_t expected_results[$];
  int fail_count = 0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Predictor state
  logic [15:0] avg_target = TARGET_AT_RESET;
  logic [15:0] avg_count = '0;
  logic avg_done = 1'b0;
  longint offset[3] = '{0, 0, 0};
  longint held_rate[3] = '{0, 0, 0};
  logic [47:0] heading_acc = '0;
  logic [31:0] good_samples = '0;
  logic fault_held = 1'b0;

  gyro_bias_calibrate_yaw_integrate_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint rate_to_dps(logic [23:0] raw);
    longint s;
    s = longint'($signed(raw));
    return (s * RAD_TO_DEG_Q16) >>> 16;
  endfunction

  function automatic gyro_result_t predict_sample(logic [23:0] rx, logic [23:0] ry,
                                                  logic [23:0] rz, logic [15:0] dt,
                                                  logic fail);
    logic [23:0] raw[3];
    longint dps[3];
    longint step;
    gyro_result_t r;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    if (fault_held || fail) begin
      fault_held = 1'b1;
      r.status = 1'b1;
    end else begin
      for (int a = 0; a < 3; a++) dps[a] = rate_to_dps(raw[a]);
      if (avg_count < avg_target) begin
        for (int a = 0; a < 3; a++)
          offset[a] = wrap32(offset[a] + (dps[a] - offset[a]) / (longint'(avg_count) + 1));
        avg_count = avg_count + 16'd1;
        if (avg_count == avg_target) avg_done = 1'b1;
      end
      for (int a = 0; a < 3; a++) held_rate[a] = wrap32(dps[a] - offset[a]);
      if (avg_done) begin
        step = (held_rate[2] * longint'(dt)) >>> 20;
        heading_acc = heading_acc + step[47:0];
      end
      good_samples = good_samples + 32'd1;
      r.status = 1'b0;
    end
    r.x_dps = held_rate[0][31:0];
    r.y_dps = held_rate[1][31:0];
    r.z_dps = held_rate[2][31:0];
    r.heading = heading_acc;
    r.calibrated = avg_done;
    r.seen = good_samples;
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gyro_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expected item: tdata %0h tuser %0h", m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("result_status", want.status, m_tuser[0]);
        compare_field("calibrated", want.calibrated, m_tuser[1]);
        compare_field("corrected_x_dps", want.x_dps, m_tdata[31:0]);
        compare_field("corrected_y_dps", want.y_dps, m_tdata[63:32]);
        compare_field("corrected_z_dps", want.z_dps, m_tdata[95:64]);
        compare_field("heading_deg", want.heading, m_tdata[143:96]);
        compare_field("samples_seen", want.seen, m_tdata[175:144]);
      end
    end
  end

  // Receiver: long holds on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic pause_sender(int cycles);
    @(negedge clk) s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_sample(logic [23:0] rx, logic [23:0] ry, logic [23:0] rz,
                             logic [15:0] dt, logic fail);
    if (tx_idle_en && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 16));
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {dt, rz, ry, rx};
    s_tuser <= fail;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_sample(rx, ry, rz, dt, fail));
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_target(logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    avg_target = value;
  endtask

  function automatic logic [23:0] pick_rate(int drift);
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3, 4: return 24'($urandom());
      default: return 24'(drift + int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(900, 1200));
    endcase
  endfunction

  task automatic run_random(int count);
    int drift[3];
    for (int a = 0; a < 3; a++) drift[a] = int'($urandom_range(0, 20000)) - 10000;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      send_sample(pick_rate(drift[0]), pick_rate(drift[1]), pick_rate(drift[2]),
                  pick_step(), 1'b0);
    end
  endtask

  task automatic test_field_extremes();
    send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b0);
    send_sample(24'h800000, 24'h800000, 24'h800000, 16'h0000, 1'b0);
    send_sample(24'h000000, 24'h000000, 24'h000000, 16'h8000, 1'b0);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h0001, 1'b0);
    send_sample(24'h7FFFFF, 24'h800000, 24'h000001, 16'hFFFF, 1'b0);
    send_sample(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 16'h0001, 1'b0);
    send_sample(24'h123456, 24'hABCDEF, 24'h555555, 16'hAAAA, 1'b0);
    send_sample(24'hAAAAAA, 24'h555555, 24'h0F0F0F, 16'h5555, 1'b0);
  endtask

  // Target below the count, then zero: averaging stops, not calibrated
  task automatic test_target_lowered();
    write_target(16'd3);
    send_sample(24'h001000, 24'hFFF000, 24'h000800, 16'd1048, 1'b0);
    send_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b0);
    write_target(16'd0);
    send_sample(24'h000100, 24'h000200, 24'hFFFF00, 16'd1048, 1'b0);
    send_sample(24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b0);
  endtask

  task automatic test_calibration_done();
    write_target(16'd12);
    repeat (4) send_sample(24'h000400, 24'hFFFC00, 24'h000200, 16'd1048, 1'b0);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b0);
    send_sample(24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 1'b0);
    send_sample(24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 1'b0);
  endtask

  // Raised target after calibration: averaging resumes, calibrated holds
  task automatic test_target_raised();
    write_target(16'hFFFF);
    send_sample(24'h000800, 24'h000800, 24'h000800, 16'd1048, 1'b0);
    send_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b0);
    send_sample(24'hFFF800, 24'hFFF800, 24'hFFF800, 16'h0000, 1'b0);
  endtask

  task automatic test_random_averaging();
    write_target(avg_count + 16'($urandom_range(100, 400)));
    run_random(500);
  endtask

  task automatic test_random_single_sample_target();
    write_target(16'd1);
    run_random(400);
  endtask

  task automatic test_backpressure();
    drain_results();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    @(posedge clk);
    hold_request = 300;
    run_random(20);
    drain_results();
    run_random(10);
  endtask

  task automatic test_back_to_back();
    write_target(16'hFFFF);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 350; i++)
      send_sample(pick_rate(0), pick_rate(0), pick_rate(0), pick_step(), 1'b0);
  endtask

  // Sticky read failure freezes all state; must run last
  task automatic test_read_failure();
    repeat (3) send_sample(pick_rate(0), pick_rate(0), pick_rate(0), pick_step(), 1'b0);
    send_sample(24'h7FFFFF, 24'h800000, 24'h123456, 16'hFFFF, 1'b1);
    repeat (10)
      send_sample(pick_rate(0), pick_rate(0), pick_rate(0), pick_step(),
                  1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_field_extremes();
    test_target_lowered();
    test_calibration_done();
    test_target_raised();
    test_random_averaging();
    test_random_single_sample_target();
    test_backpressure();
    test_back_to_back();
    test_read_failure();
    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("gyro_bias_calibrate_yaw_integrate_core test passed");
    end else begin
      $display("gyro_bias_calibrate_yaw_integrate_core test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("gyro_bias_calibrate_yaw_integrate_core test failed");
    $finish;
  end

endmodule
`default_nettype wire
